### rtl/ppfl_pkg.sv
// Shared constants for the per-CPU page free list unit: field widths,
// status codes, configuration register indexes and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package ppfl_pkg;

    localparam int ADDR_W     = 32;
    localparam int CPU_IN_W   = 3;
    localparam int STATUS_W   = 2;
    localparam int IDX_W      = 16;
    localparam int CFG_IDX_W  = 8;

    localparam logic [IDX_W-1:0] NULL_IDX = 16'hFFFF;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHYS_TOP   = 8'd1;

    localparam logic [ADDR_W-1:0] KERNEL_END_RST = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] PHYS_TOP_RST   = 32'h8800_0000;

    localparam int DEF_NUM_CPUS   = 8;
    localparam int DEF_NUM_PAGES  = 32768;
    localparam int DEF_PAGE_SHIFT = 12;

endpackage

### rtl/per_cpu_page_free_list_unit.sv
// Per-CPU page free list unit, top level.
// Depends on ppfl_pkg and ppfl_ram.
`timescale 1ns / 1ps

// Usage
// The block keeps one LIFO free list of physical pages per CPU. A request
// beat on the input channel (i_in_valid / o_in_stall) carries a mode, the
// requesting CPU and, for a free, the page address. Each request gives
// exactly one result beat on the output channel (o_out_valid / i_out_stall)
// with the allocated address and a status code.
// The head memory is read at the accepting edge. A free, and an allocate
// that finds every list empty, load the result register in S_HEAD once
// the output register is free, at the edge that for a good free also
// writes the link and the new head. An allocate that pops a page reads
// the link memory in S_HEAD and loads the result in S_LINK, once the
// output register is free, with the head write-back. The next request is
// accepted in the cycle after a result is registered.
// When the receiver stalls, a result waits in the output register; one
// further request is accepted and held at its last step until the output
// register frees, so no memory is written before its result can be shown.
// Reset empties every list through per-CPU valid flags and restores the
// configuration registers; the memories themselves are not cleared.
// Configuration (i_cfg_valid / o_cfg_ready) is always ready and must only
// be written while no request is in flight.

module per_cpu_page_free_list_unit
    import ppfl_pkg::*;
#(
    parameter int NUM_CPUS   = DEF_NUM_CPUS,
    parameter int NUM_PAGES  = DEF_NUM_PAGES,
    parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_mode,
    input  logic [CPU_IN_W-1:0]  i_cpu,
    input  logic [ADDR_W-1:0]    i_page_addr,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [ADDR_W-1:0]    o_alloc_addr,
    output logic [STATUS_W-1:0]  o_status,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int PG_W   = $clog2(NUM_PAGES);
    localparam int BASE_W = ADDR_W + 1;
    localparam int IDXF_W = BASE_W - PAGE_SHIFT;
    localparam logic [BASE_W-1:0] PMASK = BASE_W'((64'd1 << PAGE_SHIFT) - 64'd1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HEAD = 2'd1;
    localparam logic [1:0] S_LINK = 2'd2;

    // Control and configuration state.
    logic [1:0]          r_state, n_state;
    logic [NUM_CPUS-1:0] r_nonempty, n_nonempty;
    logic [ADDR_W-1:0]   r_kernel_end, r_phys_top;
    logic [BASE_W-1:0]   r_base;
    logic                r_out_valid, n_out_valid;

    // Request held while in flight.
    logic                r_mode, n_mode;
    logic [CPU_W-1:0]    r_cpu, n_cpu;
    logic [PG_W-1:0]     r_idx, n_idx;
    logic                r_bad, n_bad;
    logic                r_got, n_got;

    // Result register.
    logic [ADDR_W-1:0]   r_alloc_addr, n_alloc_addr;
    logic [STATUS_W-1:0] r_status, n_status;

    // Memory ports.
    logic                head_wr_en, head_rd_en;
    logic [CPU_W-1:0]    head_wr_addr;
    logic [IDX_W-1:0]    head_wr_data, head_rd_data;
    logic                link_wr_en, link_rd_en;
    logic [PG_W-1:0]     link_wr_addr, link_rd_addr;
    logic [IDX_W-1:0]    link_wr_data, link_rd_data;

    logic                w_accept, w_out_free;
    logic [CPU_W-1:0]    w_own, w_steal;
    logic [NUM_CPUS-1:0] w_own_oh, w_cand, w_low;
    logic [BASE_W-1:0]   w_diff;
    logic [IDXF_W-1:0]   w_idx_full;
    logic                w_bad;
    logic [BASE_W-1:0]   w_cfg_base;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // A CPU number past the configured count is served as CPU 0.
    assign w_own = (32'(i_cpu) < 32'(NUM_CPUS)) ? CPU_W'(i_cpu) : '0;

    // Stealing picks the lowest-numbered other CPU with a non-empty list.
    assign w_own_oh = NUM_CPUS'(1) << w_own;
    assign w_cand   = r_nonempty & ~w_own_oh;
    assign w_low    = w_cand & (~w_cand + NUM_CPUS'(1));

    always_comb begin
        w_steal = '0;
        for (int c = 0; c < NUM_CPUS; c++) begin
            if (w_low[c]) begin
                w_steal = w_steal | CPU_W'(c);
            end
        end
    end

    // Free address checks; the base is kept rounded up to a page already.
    assign w_diff     = {1'b0, i_page_addr} - r_base;
    assign w_idx_full = w_diff[BASE_W-1:PAGE_SHIFT];
    assign w_bad      = (BASE_W'(i_page_addr) & PMASK) != '0
                     || i_page_addr < r_kernel_end
                     || i_page_addr >= r_phys_top
                     || {1'b0, i_page_addr} < r_base
                     || w_idx_full >= IDXF_W'(NUM_PAGES);

    assign w_cfg_base = ({1'b0, i_cfg_data} + PMASK) & ~PMASK;

    always_comb begin
        n_state      = r_state;
        n_nonempty   = r_nonempty;
        n_out_valid  = r_out_valid && i_out_stall;
        n_mode       = r_mode;
        n_cpu        = r_cpu;
        n_idx        = r_idx;
        n_bad        = r_bad;
        n_got        = r_got;
        n_alloc_addr = r_alloc_addr;
        n_status     = r_status;

        head_rd_en   = 1'b0;
        head_wr_en   = 1'b0;
        head_wr_addr = r_cpu;
        head_wr_data = IDX_W'(r_idx);
        link_rd_en   = 1'b0;
        link_rd_addr = head_rd_data[PG_W-1:0];
        link_wr_en   = 1'b0;
        link_wr_addr = r_idx;
        link_wr_data = r_nonempty[r_cpu] ? head_rd_data : NULL_IDX;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mode = i_mode;
                    n_idx  = w_idx_full[PG_W-1:0];
                    n_bad  = w_bad;
                    if (i_mode) begin
                        n_cpu = w_own;
                        n_got = 1'b0;
                    end else begin
                        n_cpu = r_nonempty[w_own] ? w_own : w_steal;
                        n_got = r_nonempty[w_own] || (w_cand != '0);
                    end
                    head_rd_en = 1'b1;
                    n_state    = S_HEAD;
                end
            end
            S_HEAD: begin
                if (!r_mode && r_got) begin
                    // Head index is valid; fetch its link.
                    n_idx      = head_rd_data[PG_W-1:0];
                    link_rd_en = 1'b1;
                    n_state    = S_LINK;
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_alloc_addr = '0;
                    if (!r_mode) begin
                        n_status = ST_OOM;
                    end else if (r_bad) begin
                        n_status = ST_BADFREE;
                    end else begin
                        // Push: old head becomes the link, the page the head.
                        n_status              = ST_OK;
                        link_wr_en            = 1'b1;
                        head_wr_en            = 1'b1;
                        n_nonempty[r_cpu]     = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_LINK: begin
                if (w_out_free) begin
                    head_wr_en        = 1'b1;
                    head_wr_data      = link_rd_data;
                    n_nonempty[r_cpu] = (link_rd_data < IDX_W'(NUM_PAGES));
                    n_out_valid       = 1'b1;
                    n_status          = ST_OK;
                    n_alloc_addr      = r_base[ADDR_W-1:0]
                                      + (ADDR_W'(r_idx) << PAGE_SHIFT);
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_nonempty   <= '0;
            r_out_valid  <= 1'b0;
            r_kernel_end <= KERNEL_END_RST;
            r_phys_top   <= PHYS_TOP_RST;
            r_base       <= ({1'b0, KERNEL_END_RST} + PMASK) & ~PMASK;
        end else begin
            r_state     <= n_state;
            r_nonempty  <= n_nonempty;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_KERNEL_END: begin
                        r_kernel_end <= i_cfg_data;
                        r_base       <= w_cfg_base;
                    end
                    CFG_PHYS_TOP: begin
                        r_phys_top <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_cpu        <= n_cpu;
        r_idx        <= n_idx;
        r_bad        <= n_bad;
        r_got        <= n_got;
        r_alloc_addr <= n_alloc_addr;
        r_status     <= n_status;
    end

    assign o_out_valid  = r_out_valid;
    assign o_alloc_addr = r_alloc_addr;
    assign o_status     = r_status;

    // List heads, one entry per CPU; r_nonempty marks the live ones.
    ppfl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_CPUS),
        .AW    (CPU_W)
    ) u_head_ram (
        .i_clk     (i_clk),
        .i_wr_en   (head_wr_en),
        .i_wr_addr (head_wr_addr),
        .i_wr_data (head_wr_data),
        .i_rd_en   (head_rd_en),
        .i_rd_addr (n_cpu),
        .o_rd_data (head_rd_data)
    );

    // Link table indexed by page number.
    ppfl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_PAGES),
        .AW    (PG_W)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (link_wr_en),
        .i_wr_addr (link_wr_addr),
        .i_wr_data (link_wr_data),
        .i_rd_en   (link_rd_en),
        .i_rd_addr (link_rd_addr),
        .o_rd_data (link_rd_data)
    );

endmodule

### rtl/ppfl_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Standalone, no package dependencies.
`timescale 1ns / 1ps

module ppfl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### tb/sv/ppfl_tb_pkg.sv
// Testbench-side codes for the per-CPU page free list unit: request modes
// and the spare configuration indexes that the block must ignore.
// Depends on ppfl_pkg.
`timescale 1ns / 1ps

package ppfl_tb_pkg;

    import ppfl_pkg::*;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } t_req_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX = 8'hFF;

    localparam int PAGE_BYTES = 1 << DEF_PAGE_SHIFT;

endpackage

### tb/sv/ppfl_checker.sv
// Checker for the per-CPU page free list unit: watches the request, result
// and configuration channels, predicts every result and compares it.
// Depends on ppfl_pkg and ppfl_tb_pkg.
`timescale 1ns / 1ps

module ppfl_checker
    import ppfl_pkg::*;
    import ppfl_tb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_mode,
    input  logic [CPU_IN_W-1:0]  i_cpu,
    input  logic [ADDR_W-1:0]    i_page_addr,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [ADDR_W-1:0]    i_alloc_addr,
    input  logic [STATUS_W-1:0]  i_status,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    output int                   o_fail_cnt,
    output int                   o_pending
);

    localparam int N_CPUS  = DEF_NUM_CPUS;
    localparam int N_PAGES = DEF_NUM_PAGES;
    localparam int PSHIFT  = DEF_PAGE_SHIFT;
    localparam logic [ADDR_W:0] OFS_MASK = (33'd1 << PSHIFT) - 33'd1;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [STATUS_W-1:0] status;
    } t_page_result;

    logic [ADDR_W-1:0] kend;
    logic [ADDR_W-1:0] ptop;
    logic [IDX_W-1:0]  head_idx [N_CPUS];
    logic [IDX_W-1:0]  link_idx [N_PAGES];
    t_page_result      expected_q [$];
    int                fail_total = 0;

    assign o_fail_cnt = fail_total;

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        fail_total++;
    endtask

    // Applies one request to the private copy of the lists and returns the
    // result beat it must cause.
    task automatic predict_result(input logic mode, input logic [CPU_IN_W-1:0] cpu_in,
                                  input logic [ADDR_W-1:0] addr, output t_page_result r);
        logic [ADDR_W:0]  base;
        logic [ADDR_W:0]  ofs;
        logic [ADDR_W:0]  sum;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] h;
        logic             bad;
        logic             got;
        int               cpu;
        int               c;
        int               who;
        base = ({1'b0, kend} + OFS_MASK) & ~OFS_MASK;
        cpu = int'(cpu_in);
        if (cpu >= N_CPUS)
            cpu = 0;
        r = '0;
        if (mode == MODE_FREE) begin
            bad = (addr[PSHIFT-1:0] != '0) || (addr < kend) || (addr >= ptop) ||
                  ({1'b0, addr} < base);
            if (!bad) begin
                ofs = ({1'b0, addr} - base) >> PSHIFT;
                if (ofs >= N_PAGES || ofs >= NULL_IDX) begin
                    bad = 1'b1;
                end else begin
                    link_idx[ofs[IDX_W-1:0]] = head_idx[cpu];
                    head_idx[cpu] = ofs[IDX_W-1:0];
                end
            end
            r.status = bad ? ST_BADFREE : ST_OK;
        end else begin
            got = 1'b0;
            idx = '0;
            // Own list first, then every other list in ascending order.
            for (c = -1; c < N_CPUS && !got; c++) begin
                who = (c < 0) ? cpu : c;
                if (!(c >= 0 && c == cpu)) begin
                    h = head_idx[who];
                    if (h != NULL_IDX && h < N_PAGES) begin
                        idx = h;
                        head_idx[who] = link_idx[h];
                        got = 1'b1;
                    end
                end
            end
            if (got) begin
                sum = base + ({17'b0, idx} << PSHIFT);
                r.addr = sum[ADDR_W-1:0];
                r.status = ST_OK;
            end else begin
                r.status = ST_OOM;
            end
        end
    endtask

    always @(posedge i_clk) begin : watch_proc
        t_page_result want;
        t_page_result seen;
        int i;
        if (!i_rst_n) begin
            kend = KERNEL_END_RST;
            ptop = PHYS_TOP_RST;
            for (i = 0; i < N_CPUS; i++)
                head_idx[i] = NULL_IDX;
            expected_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_KERNEL_END: kend = i_cfg_data;
                    CFG_PHYS_TOP:   ptop = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_result(i_mode, i_cpu, i_page_addr, want);
                expected_q.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                seen.addr = i_alloc_addr;
                seen.status = i_status;
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result addr=%h status=%0d with none pending",
                                              seen.addr, seen.status));
                end else begin
                    want = expected_q.pop_front();
                    if (seen.addr !== want.addr)
                        report_mismatch($sformatf("alloc_addr got %h want %h",
                                                  seen.addr, want.addr));
                    if (seen.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  seen.status, want.status));
                end
            end
            o_pending <= expected_q.size();
        end
    end

endmodule

### tb/sv/tb.sv
// Top of the per-CPU page free list testbench: clock, reset, request and
// configuration stimulus, result stall pattern, watchdog and verdict.
// Depends on ppfl_pkg, ppfl_tb_pkg, ppfl_checker and the block itself.
`timescale 1ns / 1ps

module tb;

    import ppfl_pkg::*;
    import ppfl_tb_pkg::*;

    localparam int PSHIFT         = DEF_PAGE_SHIFT;
    localparam int N_PAGES        = DEF_NUM_PAGES;
    localparam int RAND_PER_PHASE = 100;
    localparam int N_PHASES       = 7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 16;
    localparam logic [ADDR_W:0] PAGE_MASK = (33'd1 << PSHIFT) - 33'd1;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic                 i_mode      = 1'b0;
    logic [CPU_IN_W-1:0]  i_cpu       = '0;
    logic [ADDR_W-1:0]    i_page_addr = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [ADDR_W-1:0]    o_alloc_addr;
    logic [STATUS_W-1:0]  o_status;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ADDR_W-1:0]    i_cfg_data  = '0;

    int fail_cnt;
    int pending;

    // When set, neither the sender nor the receiver idles, so the block
    // runs at its full rate for a whole phase.
    logic quiet = 1'b0;

    // The configuration as last written; used only to aim free addresses
    // at interesting places, never to predict results.
    logic [ADDR_W-1:0] kend_cur = KERNEL_END_RST;
    logic [ADDR_W-1:0] ptop_cur = PHYS_TOP_RST;

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    per_cpu_page_free_list_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_cpu        (i_cpu),
        .i_page_addr  (i_page_addr),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_alloc_addr (o_alloc_addr),
        .o_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    ppfl_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_cpu        (i_cpu),
        .i_page_addr  (i_page_addr),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_alloc_addr (o_alloc_addr),
        .i_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_cnt   (fail_cnt),
        .o_pending    (pending)
    );

    // Result side. After every result beat the receiver draws a random stall
    // length, zero in a quiet phase. While no result is offered it also raises
    // stall now and then, so that a result can find the receiver already stalled.
    always @(posedge i_clk) begin : result_sink
        int hold;
        int stall_left;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (o_out_valid && !i_out_stall) begin
            hold = quiet ? 0 : $urandom_range(0, 3);
            i_out_stall <= (hold != 0);
            stall_left = (hold > 0) ? hold - 1 : 0;
        end else if (i_out_stall) begin
            if (stall_left == 0)
                i_out_stall <= 1'b0;
            else
                stall_left = stall_left - 1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end
    end

    // Watchdog: any beat on any channel restarts the count. A block that
    // hangs ends the run here.
    always @(posedge i_clk) begin : watchdog
        int idle_cycles;
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                     (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Offers one request beat and returns at the edge where it is taken.
    // Valid is left high so that a back-to-back beat needs no toggle; a drain,
    // or a next call that draws a gap, lowers it.
    task automatic send_req(input t_req_mode mode, input logic [CPU_IN_W-1:0] cpu,
                            input logic [ADDR_W-1:0] addr);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= mode;
        i_cpu       <= cpu;
        i_page_addr <= addr;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stops the request stream and waits until every expected result has
    // come back. The pending count is registered, so the loop always waits
    // on the clock before it trusts it.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // One configuration beat; valid stays high for a following beat and
    // the caller lowers it.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_KERNEL_END)
            kend_cur = data;
        else if (idx == CFG_PHYS_TOP)
            ptop_cur = data;
    endtask

    initial begin : stimulus
        int               ph;
        int               n;
        int               free_pct;
        int               dup_pct;
        int               draw;
        int               pages_ok;
        int               fresh_idx;
        logic [ADDR_W-1:0] k_new;
        logic [ADDR_W-1:0] p_new;
        logic             phase_quiet;
        logic [ADDR_W:0]  base;
        logic [ADDR_W:0]  span;
        logic [ADDR_W:0]  sum;
        logic [ADDR_W:0]  idx33;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] last_good;
        t_req_mode        mode;

        fresh_idx = 16;
        last_good = KERNEL_END_RST;

        // Synchronous reset held at the start, then never again.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset configuration: base 0x8000_0000 and
        // exactly NUM_PAGES pages below phys_top.
        send_req(MODE_ALLOC, 3'd0, 32'h0000_0000);   // every list empty
        send_req(MODE_FREE,  3'd0, 32'h8000_0001);   // not page aligned
        send_req(MODE_FREE,  3'd1, 32'h7FFF_F000);   // below kernel_end
        send_req(MODE_FREE,  3'd2, 32'h8800_0000);   // at phys_top
        send_req(MODE_FREE,  3'd3, 32'h0000_0000);
        send_req(MODE_FREE,  3'd7, 32'hFFFF_FFFF);
        send_req(MODE_FREE,  3'd0, 32'h8000_0000);   // first page
        send_req(MODE_FREE,  3'd7, 32'h87FF_F000);   // last page
        send_req(MODE_ALLOC, 3'd7, 32'hFFFF_FFFF);   // own list
        send_req(MODE_ALLOC, 3'd5, 32'h0000_0000);   // steals from CPU 0
        send_req(MODE_ALLOC, 3'd2, 32'h0000_0000);   // empty again
        send_req(MODE_FREE,  3'd3, 32'h8000_1000);
        send_req(MODE_FREE,  3'd6, 32'h8000_2000);
        send_req(MODE_ALLOC, 3'd0, 32'h0000_0000);   // lowest donor first
        send_req(MODE_ALLOC, 3'd0, 32'h0000_0000);
        // Double free onto a second CPU: both lists then share the page,
        // and it is handed out twice. No list is left cyclic.
        send_req(MODE_FREE,  3'd0, 32'h8000_3000);
        send_req(MODE_FREE,  3'd0, 32'h8000_4000);
        send_req(MODE_FREE,  3'd1, 32'h8000_3000);
        send_req(MODE_ALLOC, 3'd0, 32'h0000_0000);
        send_req(MODE_ALLOC, 3'd0, 32'h0000_0000);
        send_req(MODE_ALLOC, 3'd1, 32'h0000_0000);
        send_req(MODE_ALLOC, 3'd4, 32'h0000_0000);
        // Left on a list so that later base changes move its address.
        send_req(MODE_FREE,  3'd2, 32'h8000_5000);

        for (ph = 0; ph < N_PHASES; ph++) begin
            // Each phase picks a register setting, a mix of frees and
            // allocates, and whether the channels idle at all.
            dup_pct = 0;
            phase_quiet = 1'b0;
            case (ph)
                0: begin
                    k_new = KERNEL_END_RST; p_new = PHYS_TOP_RST; free_pct = 50;
                end
                1: begin
                    // Whole address space; high frees land past the table.
                    k_new = 32'h0000_0000; p_new = 32'hFFFF_FFFF; free_pct = 50;
                    phase_quiet = 1'b1;
                end
                2: begin
                    // Unaligned kernel_end, so the base is rounded up.
                    k_new = 32'h0000_1234; p_new = 32'h0010_0000; free_pct = 70;
                end
                3: begin
                    // The base rounds past 32 bits: every free is refused and
                    // the pages left over come back at wrapped addresses.
                    k_new = 32'hFFFF_FFFF; p_new = 32'hFFFF_FFFF; free_pct = 20;
                end
                4: begin
                    // phys_top below kernel_end: nothing can be freed.
                    k_new = 32'h9000_0000; p_new = 32'h8000_0000; free_pct = 40;
                end
                5: begin
                    // A single usable page at the top of the address space.
                    k_new = 32'hFFFF_F000; p_new = 32'hFFFF_FFFF; free_pct = 40;
                    phase_quiet = 1'b1;
                end
                default: begin
                    k_new = KERNEL_END_RST; p_new = PHYS_TOP_RST; free_pct = 50;
                    dup_pct = 10;
                end
            endcase

            drain();
            quiet <= phase_quiet;
            if (ph != 0) begin
                cfg_write(CFG_KERNEL_END, k_new);
                cfg_write(CFG_PHYS_TOP, p_new);
                // Writes to indexes past the register list must change nothing.
                if (ph == N_PHASES - 1) begin
                    cfg_write(CFG_SPARE, $urandom);
                    cfg_write(CFG_TOP_IDX, $urandom);
                end
                i_cfg_valid <= 1'b0;
            end

            if (ph == 1) begin
                // Index one past the table, and index 0xFFFF0, far past it.
                send_req(MODE_FREE, 3'd4, 32'h0800_0000);
                send_req(MODE_FREE, 3'd4, 32'hFFFF_0000);
            end

            base = ({1'b0, kend_cur} + PAGE_MASK) & ~PAGE_MASK;
            if ({1'b0, ptop_cur} > base)
                span = ({1'b0, ptop_cur} - base + PAGE_MASK) >> PSHIFT;
            else
                span = '0;
            pages_ok = (span > N_PAGES) ? N_PAGES : int'(span);

            for (n = 0; n < RAND_PER_PHASE; n++) begin
                // Once, the sender holds off until the block has answered
                // everything, then resumes.
                if (ph == 2 && n == RAND_PER_PHASE / 2)
                    drain();

                mode = ($urandom_range(0, 99) < free_pct) ? MODE_FREE : MODE_ALLOC;
                addr = $urandom;
                if (mode == MODE_FREE) begin
                    // Mostly well-formed frees of fresh pages so that lists
                    // grow, get stolen from and run dry; the rest probe the
                    // address checks.
                    draw = $urandom_range(0, 99);
                    if (draw < dup_pct) begin
                        addr = last_good;
                    end else if (draw < 60 && pages_ok != 0) begin
                        idx33 = 33'(fresh_idx % pages_ok);
                        fresh_idx++;
                        sum = base + (idx33 << PSHIFT);
                        addr = sum[ADDR_W-1:0];
                        last_good = addr;
                    end else if (draw < 66 && pages_ok != 0) begin
                        idx33 = 33'(pages_ok - 1);
                        sum = base + (idx33 << PSHIFT);
                        addr = sum[ADDR_W-1:0];
                    end else if (draw < 72) begin
                        idx33 = 33'(N_PAGES + $urandom_range(0, 3));
                        sum = base + (idx33 << PSHIFT);
                        addr = sum[ADDR_W-1:0];
                    end else if (draw < 80) begin
                        addr = base[ADDR_W-1:0] + ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
                    end else if (draw < 86) begin
                        addr = kend_cur - ADDR_W'(PAGE_BYTES * $urandom_range(1, 4));
                    end else if (draw < 92) begin
                        addr = ptop_cur & ~PAGE_MASK[ADDR_W-1:0];
                    end
                end
                send_req(mode, CPU_IN_W'($urandom_range(0, 7)), addr);
            end
        end

        // Let every result come home, then watch a little longer for any
        // beat the block should not have sent.
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
